// File: design/aging_name_registry_table_top_macros.svh
// assertion macros for the registry table
`ifndef AGING_NAME_REGISTRY_TABLE_TOP_MACROS_SVH
`define AGING_NAME_REGISTRY_TABLE_TOP_MACROS_SVH
`ifndef SYNTH
`define ANR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ANR_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ANR_ASSERT(label, clk, rst_n, prop, msg)
`define ANR_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: design/anrt_pkg.sv
// ----------------------------------------------------------------------------
// anrt_pkg
// types and constants shared by the registry table modules
// ----------------------------------------------------------------------------
package anrt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [15:0] STALE_RESET = 16'd30;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_REGISTER  = 2'd0,
        OP_LOOKUP    = 2'd1,
        OP_HEARTBEAT = 2'd2,
        OP_PURGE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_STALE_LIMIT = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] name_key;
        logic [31:0] ip_addr;
        logic [15:0] port_num;
        logic [31:0] now_time;
        logic [31:0] seq_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_ip;
        logic [15:0] found_port;
        logic [6:0]  removed_count;
        logic [31:0] seq_echo;
    } rsp_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t         op;
        logic        search;
        logic [63:0] name_key;
        logic [31:0] ip_addr;
        logic [15:0] port_num;
        logic [31:0] now_time;
        logic [31:0] seq_tag;
    } cmd_t;

endpackage

// File: design/aging_name_registry_table_top.sv
// ----------------------------------------------------------------------------
// aging_name_registry_table_top
// name registry table with register, lookup, heartbeat and stale purge
// ----------------------------------------------------------------------------
// usage:
// - request channel in_valid/in_ready/in_data carries one request per transfer
// - result channel out_valid/out_ready/out_data returns exactly one result per
//   request, in request order
// - stale_limit is written over the apb port at address 0 while idle
// - a request waits in a two-entry queue, then the back end walks the table
//   one slot per cycle through its registered memory read port
// - a search stops early at its hit
// - the back end takes the next request only after its result transfer; the
//   queue keeps accepting while the back end works and while a result waits
// - reset empties the table and sets stale_limit to 30
// - a stalled receiver holds the result register; the back end then waits
//   and the queue fills until in_ready drops
// ----------------------------------------------------------------------------
module aging_name_registry_table_top
    import anrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        cmd_valid, cmd_ready;
    cmd_t        cmd_data;
    logic [15:0] stale_limit_reg;

    // single register at word 0
    assign pready = 1'b1;
    assign prdata = (paddr == {REG_STALE_LIMIT, 1'b0}) ? {16'd0, stale_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg <= STALE_RESET;
        end
        else if (psel && penable && pwrite && paddr == {REG_STALE_LIMIT, 1'b0})
        begin
            stale_limit_reg <= pwdata[15:0];
        end
    end

    // front end: request queue
    anrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    // back end: table walk and result register
    anrt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data),
        .stale_limit (stale_limit_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// File: design/anrt_front.sv
// ----------------------------------------------------------------------------
// anrt_front
// accepts requests, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`include "aging_name_registry_table_top_macros.svh"
module anrt_front
    import anrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd_data
);

    cmd_t q_reg [QUEUE_DEPTH];
    logic [0:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t cls;
    logic push, pop;

    always_comb
    begin
        cls.op       = op_t'(in_data.op);
        cls.search   = (in_data.op != OP_PURGE);
        cls.name_key = in_data.name_key;
        cls.ip_addr  = in_data.ip_addr;
        cls.port_num = in_data.port_num;
        cls.now_time = in_data.now_time;
        cls.seq_tag  = in_data.seq_tag;
    end

    assign in_ready  = (cnt_reg != 2'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `ANR_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= 2'(QUEUE_DEPTH), "queue overfilled")
    `ANR_ASSERT(a_ptr_gap, clk, rst_n, (cnt_reg == 2'd1) |-> (wp_reg != rp_reg), "queue pointers disagree with count")
    `ANR_ASSERT(a_push_cnt, clk, rst_n, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1), "push lost")

endmodule

// File: design/anrt_back.sv
// ----------------------------------------------------------------------------
// anrt_back
// walks the table one slot a cycle to search, update or compact it
// ----------------------------------------------------------------------------
`include "aging_name_registry_table_top_macros.svh"
module anrt_back
    import anrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd_data,
    input  logic [15:0] stale_limit,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WAIT  = 5'b00100,
        S_APPLY = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    logic [63:0] mem_key  [TABLE_ENTRIES];
    logic [31:0] mem_ip   [TABLE_ENTRIES];
    logic [15:0] mem_port [TABLE_ENTRIES];
    logic [31:0] mem_time [TABLE_ENTRIES];

    state_t state_reg, state_next;
    cmd_t cmd_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [6:0] removed_reg, removed_next;
    logic rvalid_reg, rvalid_next;
    logic [IDX_W-1:0] ridx_reg;
    logic [63:0] rkey_reg;
    logic [31:0] rip_reg, rtime_reg;
    logic [15:0] rport_reg;
    logic hit_reg, hit_next;
    logic [IDX_W-1:0] hidx_reg, hidx_next;
    logic [31:0] hip_reg, hip_next, htime_reg, htime_next;
    logic [15:0] hport_reg, hport_next;
    logic ovalid_reg, ovalid_next;
    rsp_t odata_reg, odata_next;

    logic rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic we, we_key;
    logic [IDX_W-1:0] widx;
    logic [63:0] wkey;
    logic [31:0] wip, wtime;
    logic [15:0] wport;
    logic [31:0] age;
    logic stale_r;

    assign age     = cmd_reg.now_time - rtime_reg;
    assign stale_r = (age > {16'd0, stale_limit});
    assign cmd_ready = state_reg[0] && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        removed_next = removed_reg;
        rvalid_next  = 1'b0;
        hit_next     = hit_reg;
        hidx_next    = hidx_reg;
        hip_next     = hip_reg;
        hport_next   = hport_reg;
        htime_next   = htime_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        odata_next   = odata_reg;
        rd_en  = 1'b0;
        rd_idx = rd_reg[IDX_W-1:0];
        we = 1'b0;
        we_key = 1'b0;
        widx  = wr_reg[IDX_W-1:0];
        wkey  = rkey_reg;
        wip   = rip_reg;
        wport = rport_reg;
        wtime = rtime_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    state_next   = S_SCAN;
                    rd_next      = '0;
                    wr_next      = '0;
                    removed_next = '0;
                    hit_next     = 1'b0;
                end
            end
            S_SCAN:
            begin
                // issue one read a cycle, evaluate the previous read
                if (rd_reg < count_reg && !(cmd_reg.search && hit_reg))
                begin
                    rd_en = 1'b1;
                    rvalid_next = 1'b1;
                    rd_next = rd_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_WAIT;
                end
                if (rvalid_reg)
                begin
                    if (cmd_reg.search)
                    begin
                        if (!hit_reg && rkey_reg == cmd_reg.name_key)
                        begin
                            hit_next   = 1'b1;
                            hidx_next  = ridx_reg;
                            hip_next   = rip_reg;
                            hport_next = rport_reg;
                            htime_next = rtime_reg;
                            rd_en = 1'b0;
                            rvalid_next = 1'b0;
                            state_next = S_WAIT;
                        end
                    end
                    else if (stale_r)
                    begin
                        removed_next = removed_reg + 7'd1;
                    end
                    else
                    begin
                        we = 1'b1;
                        we_key = 1'b1;
                        wr_next = wr_reg + CNT_W'(1);
                    end
                end
            end
            S_WAIT:
            begin
                // last read in flight is evaluated here
                if (rvalid_reg)
                begin
                    if (cmd_reg.search)
                    begin
                        if (!hit_reg && rkey_reg == cmd_reg.name_key)
                        begin
                            hit_next   = 1'b1;
                            hidx_next  = ridx_reg;
                            hip_next   = rip_reg;
                            hport_next = rport_reg;
                            htime_next = rtime_reg;
                        end
                    end
                    else if (stale_r)
                    begin
                        removed_next = removed_reg + 7'd1;
                    end
                    else
                    begin
                        we = 1'b1;
                        we_key = 1'b1;
                        wr_next = wr_reg + CNT_W'(1);
                    end
                end
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                odata_next.status        = ST_OK;
                odata_next.found_ip      = '0;
                odata_next.found_port    = '0;
                odata_next.removed_count = '0;
                odata_next.seq_echo      = cmd_reg.seq_tag;
                wkey  = cmd_reg.name_key;
                wip   = cmd_reg.ip_addr;
                wport = cmd_reg.port_num;
                wtime = cmd_reg.now_time;
                unique case (cmd_reg.op)
                    OP_REGISTER:
                    begin
                        if (hit_reg)
                        begin
                            we = 1'b1;
                            widx = hidx_reg;
                        end
                        else if (count_reg < CNT_W'(TABLE_ENTRIES))
                        begin
                            we = 1'b1;
                            we_key = 1'b1;
                            widx = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            odata_next.status = ST_FULL;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit_reg && (cmd_reg.now_time - htime_reg) <= {16'd0, stale_limit})
                        begin
                            odata_next.found_ip   = hip_reg;
                            odata_next.found_port = hport_reg;
                        end
                        else
                        begin
                            odata_next.status = ST_MISSING;
                        end
                    end
                    OP_HEARTBEAT:
                    begin
                        if (hit_reg)
                        begin
                            we = 1'b1;
                            widx = hidx_reg;
                            wip = hip_reg;
                            wport = hport_reg;
                        end
                    end
                    OP_PURGE:
                    begin
                        count_next = wr_reg;
                        odata_next.removed_count = removed_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rkey_reg  <= mem_key[rd_idx];
            rip_reg   <= mem_ip[rd_idx];
            rport_reg <= mem_port[rd_idx];
            rtime_reg <= mem_time[rd_idx];
            ridx_reg  <= rd_idx;
        end
        if (we)
        begin
            if (we_key)
            begin
                mem_key[widx] <= wkey;
            end
            mem_ip[widx]   <= wip;
            mem_port[widx] <= wport;
            mem_time[widx] <= wtime;
        end
        if (state_reg == S_IDLE && cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd_data;
        end
        hidx_reg  <= hidx_next;
        hip_reg   <= hip_next;
        hport_reg <= hport_next;
        htime_reg <= htime_next;
        odata_reg <= odata_next;
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        removed_reg <= removed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            hit_reg    <= hit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    `ANR_ASSERT(a_count_max, clk, rst_n, count_reg <= CNT_W'(TABLE_ENTRIES), "entry count above table size")
    `ANR_ASSERT(a_wr_le_rd, clk, rst_n, state_reg == S_SCAN |-> wr_reg <= rd_reg, "compaction writer ahead of reader")
    `ANR_ASSERT(a_hold_out, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result dropped while stalled")
    `ANR_ASSERT(a_done_out, clk, rst_n, state_reg == S_DONE |=> out_valid, "result not raised after done")

endmodule
